[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the page order counter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/apoc_pkg.sv]
// ----------------------------------------------------------------------------
// apoc_pkg
// Types and fixed constants of the aligned page order counter.
// ----------------------------------------------------------------------------
package apoc_pkg;

  localparam int ORDER_FIELD_W = 5;
  localparam int PAGES_W       = 37;
  localparam int TOTAL_W       = 48;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_ORDER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_VIRTUAL = 2'd1;

  localparam logic [ORDER_FIELD_W-1:0] TOP_ORDER_RESET = 5'd30;
  localparam logic [TOTAL_W-1:0]       TOTAL_MAX       = '1;

  // Control from the sequencer to the shared split unit.
  typedef struct packed {
    logic load;      // capture the alignment phase of the current piece
    logic match_en;  // physical and virtual offsets must agree
  } apoc_unit_ctrl_t;

endpackage

[sv/apoc_cfg_if.sv]
// ----------------------------------------------------------------------------
// apoc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface apoc_cfg_if import apoc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/apoc_in_if.sv]
// ----------------------------------------------------------------------------
// apoc_in_if
// Region channel: start, end and virtual start of one address region.
// ----------------------------------------------------------------------------
interface apoc_in_if #(parameter int ADDR_BITS = 48) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] region_start;
  logic [ADDR_BITS-1:0] region_end;
  logic [ADDR_BITS-1:0] virtual_start;

  modport source (output valid, output region_start, output region_end,
                  output virtual_start, input ready);
  modport sink   (input valid, input region_start, input region_end,
                  input virtual_start, output ready);
endinterface

[sv/apoc_out_if.sv]
// ----------------------------------------------------------------------------
// apoc_out_if
// Result channel: per-order page count and running total.
// ----------------------------------------------------------------------------
interface apoc_out_if import apoc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ORDER_FIELD_W-1:0] page_order;
  logic [PAGES_W-1:0]       region_pages;
  logic [TOTAL_W-1:0]       order_total;
  logic                     last;

  modport source (output valid, output page_order, output region_pages,
                  output order_total, output last, input ready);
  modport sink   (input valid, input page_order, input region_pages,
                  input order_total, input last, output ready);
endinterface

[sv/aligned_page_order_counter.sv]
// ----------------------------------------------------------------------------
// aligned_page_order_counter
// Splits address regions into naturally aligned power-of-two pages and keeps
// a saturating page count per order.
//
// Channels: in_if carries one region per transaction (start, exclusive end,
// virtual start). out_if returns NUM_ORDERS transactions per region, from the
// highest order down; last marks the lowest order. cfg_if writes top_order
// (index 0) and match_virtual (index 1) and is always ready; write it only
// while the block is idle.
// One region at a time. An order above top_order goes straight to its result;
// while the region is still one piece, an order runs that piece through the
// split unit, and once it has split into a lower and an upper piece, both
// pieces pass through the single two-phase split unit in turn. The first
// order tried is never split. in_if.ready is low until the last result of
// the region is written.
// Reset: totals clear to zero, top_order returns to 30, match_virtual to 0.
// Stall: results leave through a one-entry output register; while it is full
// and out_if.ready is low the sequencer holds before writing the next total.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aligned_page_order_counter import apoc_pkg::*; #(
  parameter int ADDR_BITS    = 48,
  parameter int LOWEST_ORDER = 12,
  parameter int NUM_ORDERS   = 19
) (
  input  logic    clk,
  input  logic    rst_n,
  apoc_cfg_if.sink    cfg_if,
  apoc_in_if.sink     in_if,
  apoc_out_if.source  out_if
);

  localparam int MAX_ORD  = LOWEST_ORDER + NUM_ORDERS - 1;
  localparam int ORD_W    = (MAX_ORD > 1) ? $clog2(MAX_ORD + 1) : 1;
  localparam int IDX_W    = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int CMP_W    = (ORD_W > ORDER_FIELD_W) ? ORD_W : ORDER_FIELD_W;

  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NUM_ORDERS - 1);
  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORD);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_L_A  = 3'd1;
  localparam logic [2:0] ST_L_B  = 3'd2;
  localparam logic [2:0] ST_H_A  = 3'd3;
  localparam logic [2:0] ST_H_B  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     split_r, split_nxt;
  logic [PAGES_W-1:0]       cnt_r, cnt_nxt;
  logic [ORDER_FIELD_W-1:0] top_r;
  logic                     match_r;

  // Lower piece (end aligned once split) and upper piece (start aligned).
  logic [ADDR_BITS-1:0] s_l_r, e_l_r, v_l_r;
  logic [ADDR_BITS-1:0] s_h_r, e_h_r, v_h_r;

  logic                     out_valid_r;
  logic [ORDER_FIELD_W-1:0] out_order_r;
  logic [PAGES_W-1:0]       out_pages_r;
  logic [TOTAL_W-1:0]       out_total_r;
  logic                     out_last_r;

  logic [ORD_W-1:0]     k_cur;
  logic [ORD_W-1:0]     k_dn;
  logic                 act_top;
  logic                 act_dn;
  logic                 use_h;
  logic                 in_fire;
  logic                 emit_fire;
  apoc_unit_ctrl_t      u_ctrl;
  logic                 u_place;
  logic [PAGES_W-1:0]   u_count;
  logic [ADDR_BITS-1:0] u_lo_end, u_hi_start, u_hi_virt;
  logic [TOTAL_W-1:0]   total_new;

  always_comb begin
    k_cur   = ORD_W'(LOWEST_ORDER) + ORD_W'(idx_r);
    k_dn    = k_cur - ORD_W'(1);
    act_top = CMP_W'(ORD_MAX) <= CMP_W'(top_r);
    act_dn  = CMP_W'(k_dn) <= CMP_W'(top_r);
  end

  assign use_h           = (state_r == ST_H_A) || (state_r == ST_H_B);
  assign u_ctrl.load     = (state_r == ST_L_A) || (state_r == ST_H_A);
  assign u_ctrl.match_en = match_r;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign emit_fire   = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  apoc_split_unit #(
    .ADDR_BITS (ADDR_BITS),
    .ORD_W     (ORD_W)
  ) u_split (
    .clk         (clk),
    .ctrl        (u_ctrl),
    .piece_start (use_h ? s_h_r : s_l_r),
    .piece_end   (use_h ? e_h_r : e_l_r),
    .piece_virt  (use_h ? v_h_r : v_l_r),
    .order       (k_cur),
    .place       (u_place),
    .count       (u_count),
    .lo_end      (u_lo_end),
    .hi_start    (u_hi_start),
    .hi_virt     (u_hi_virt)
  );

  apoc_totals #(
    .NUM_ORDERS (NUM_ORDERS),
    .IDX_W      (IDX_W)
  ) u_totals (
    .clk       (clk),
    .rst_n     (rst_n),
    .idx       (idx_r),
    .pages     (cnt_r),
    .wr_en     (emit_fire),
    .total_new (total_new)
  );

  // Sequencer: per order, lower piece, then upper piece once split, then the result.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    split_nxt = split_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = IDX_TOP;
          split_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = act_top ? ST_L_A : ST_EMIT;
        end
      end
      ST_L_A: state_nxt = ST_L_B;
      ST_L_B: begin
        if (u_place) begin
          cnt_nxt   = cnt_r + u_count;
          split_nxt = 1'b1;
        end
        // A piece split off at this order cannot hold a page of this order.
        state_nxt = split_r ? ST_H_A : ST_EMIT;
      end
      ST_H_A: state_nxt = ST_H_B;
      ST_H_B: begin
        if (u_place) begin
          cnt_nxt = cnt_r + u_count;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          cnt_nxt = '0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = act_dn ? ST_L_A : ST_EMIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      split_r     <= 1'b0;
      cnt_r       <= '0;
      top_r       <= TOP_ORDER_RESET;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      split_r <= split_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          REG_TOP_ORDER:     top_r   <= cfg_if.data[ORDER_FIELD_W-1:0];
          REG_MATCH_VIRTUAL: match_r <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Piece and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_l_r <= in_if.region_start;
      e_l_r <= in_if.region_end;
      v_l_r <= in_if.virtual_start;
      s_h_r <= '0;
      e_h_r <= '0;
      v_h_r <= '0;
    end else if ((state_r == ST_L_B) && u_place) begin
      e_l_r <= u_lo_end;
      if (!split_r) begin
        s_h_r <= u_hi_start;
        e_h_r <= e_l_r;
        v_h_r <= u_hi_virt;
      end
    end else if ((state_r == ST_H_B) && u_place) begin
      s_h_r <= u_hi_start;
      v_h_r <= u_hi_virt;
    end
    if (emit_fire) begin
      out_order_r <= ORDER_FIELD_W'(k_cur);
      out_pages_r <= cnt_r;
      out_total_r <= total_new;
      out_last_r  <= (idx_r == '0);
    end
  end

  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.page_order   = out_order_r;
  assign out_if.region_pages = out_pages_r;
  assign out_if.order_total  = out_total_r;
  assign out_if.last         = out_last_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_if.valid && in_if.ready,
    !in_if.ready, "region accepted while a region is still in progress")
  `ASSERT_IMPLIES(a_last_is_lowest, clk, rst_n, out_if.valid && out_if.last,
    out_if.page_order == ORDER_FIELD_W'(LOWEST_ORDER), "last result not at lowest order")
  `ASSERT_IMPLIES(a_total_covers_pages, clk, rst_n, out_if.valid,
    TOTAL_W'(out_if.region_pages) <= out_if.order_total, "total below region page count")

endmodule

[sv/apoc_split_unit.sv]
// ----------------------------------------------------------------------------
// apoc_split_unit
// Shared two-phase unit that places aligned pages of one order in one piece.
// Phase one aligns the piece bounds and checks the virtual offset; phase two
// counts the pages and moves the virtual start to the upper leftover piece.
// ----------------------------------------------------------------------------
module apoc_split_unit import apoc_pkg::*; #(
  parameter int ADDR_BITS = 48,
  parameter int ORD_W     = 5
) (
  input  logic                 clk,
  input  apoc_unit_ctrl_t      ctrl,
  input  logic [ADDR_BITS-1:0] piece_start,
  input  logic [ADDR_BITS-1:0] piece_end,
  input  logic [ADDR_BITS-1:0] piece_virt,
  input  logic [ORD_W-1:0]     order,
  output logic                 place,
  output logic [PAGES_W-1:0]   count,
  output logic [ADDR_BITS-1:0] lo_end,
  output logic [ADDR_BITS-1:0] hi_start,
  output logic [ADDR_BITS-1:0] hi_virt
);

  localparam int CW = (ADDR_BITS > PAGES_W) ? ADDR_BITS : PAGES_W;

  logic [ADDR_BITS-1:0] mask;
  logic [ADDR_BITS:0]   up;
  logic [ADDR_BITS:0]   lo_a;
  logic [ADDR_BITS-1:0] hi_a;
  logic [ADDR_BITS-1:0] off_a;
  logic                 match_ok;
  logic                 place_a;

  logic [ADDR_BITS-1:0] lo_r;
  logic [ADDR_BITS-1:0] hi_r;
  logic [ADDR_BITS-1:0] off_r;
  logic                 place_r;

  logic [ADDR_BITS-1:0] diff;
  logic [CW-1:0]        diff_w;

  // Alignment phase. The start rounds up, so the sum carries one extra bit.
  always_comb begin
    mask     = ~({ADDR_BITS{1'b1}} << order);
    up       = {1'b0, piece_start} + {1'b0, mask};
    lo_a     = up & ~{1'b0, mask};
    hi_a     = piece_end & ~mask;
    off_a    = piece_virt - piece_start;
    match_ok = !ctrl.match_en || (((piece_start ^ piece_virt) & mask) == '0);
    place_a  = match_ok && (lo_a < {1'b0, hi_a});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      lo_r    <= lo_a[ADDR_BITS-1:0];
      hi_r    <= hi_a;
      off_r   <= off_a;
      place_r <= place_a;
    end
  end

  // Count phase. When pages are placed the aligned start lies below the
  // aligned end, so the dropped carry bit is zero.
  always_comb begin
    diff   = hi_r - lo_r;
    diff_w = CW'(diff) >> order;
  end

  assign place    = place_r;
  assign count    = diff_w[PAGES_W-1:0];
  assign lo_end   = lo_r;
  assign hi_start = hi_r;
  assign hi_virt  = hi_r + off_r;

endmodule

[sv/apoc_totals.sv]
// ----------------------------------------------------------------------------
// apoc_totals
// Running page totals, one per order, with a saturating update.
// ----------------------------------------------------------------------------
module apoc_totals import apoc_pkg::*; #(
  parameter int NUM_ORDERS = 19,
  parameter int IDX_W      = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IDX_W-1:0]   idx,
  input  logic [PAGES_W-1:0] pages,
  input  logic               wr_en,
  output logic [TOTAL_W-1:0] total_new
);

  logic [TOTAL_W-1:0] total_r [NUM_ORDERS];
  logic [TOTAL_W:0]   sum;

  always_comb begin
    sum       = {1'b0, total_r[idx]} + (TOTAL_W+1)'(pages);
    total_new = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        total_r[i] <= '0;
      end
    end else if (wr_en) begin
      total_r[idx] <= total_new;
    end
  end

endmodule
